>>> rtl/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int ADDR_W            = 48;   // address width on the ports
    localparam int FLAG_W            = 32;
    localparam int COUNT_W           = 5;
    localparam int RESULT_LIMIT      = 16;   // most results one range query gives
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_ADDR_BITS     = 48;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_FIND       = 2'd2,
        OP_QUERY      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } t_state;

    typedef struct packed {
        t_op                 cmd;
        logic [ADDR_W-1:0]   region_start;
        logic [ADDR_W-1:0]   region_end;
        logic [FLAG_W-1:0]   region_flags;
        logic [ADDR_W-1:0]   lookup_addr;
    } t_cmd_item;

    typedef struct packed {
        t_status             status;
        logic                entry_valid;
        logic [ADDR_W-1:0]   match_start;
        logic [ADDR_W-1:0]   match_end;
        logic [FLAG_W-1:0]   match_flags;
        logic [COUNT_W-1:0]  match_count;
        logic                last;
    } t_result;

    // control broadcast to the row of table cells
    typedef struct packed {
        logic rotate;    // every cell takes its upper neighbour
        logic compact;   // cells at or above the delete index take their neighbour
    } t_cell_ctrl;

endpackage

>>> rtl/art_cell.sv
// ----------------------------------------------------------------------------
// art_cell
// One table entry. Loads from its upper neighbour when the ring rotates, or
// when a removal closes the gap at or below its own position.
// ----------------------------------------------------------------------------
module art_cell #(
    parameter int ADDR_BITS = 48,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                        i_clk,
    input  art_pkg::t_cell_ctrl         i_ctrl,
    input  logic [IDX_W-1:0]            i_del_idx,
    input  logic [ADDR_BITS-1:0]        i_nb_start,
    input  logic [ADDR_BITS-1:0]        i_nb_end,
    input  logic [art_pkg::FLAG_W-1:0]  i_nb_flags,
    output logic [ADDR_BITS-1:0]        o_start,
    output logic [ADDR_BITS-1:0]        o_end,
    output logic [art_pkg::FLAG_W-1:0]  o_flags
);
    import art_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ADDR_BITS-1:0] r_start;
    logic [ADDR_BITS-1:0] r_end;
    logic [FLAG_W-1:0]    r_flags;
    logic                 take;

    assign take = i_ctrl.rotate | (i_ctrl.compact & (MY_IDX >= i_del_idx));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_start <= i_nb_start;
            r_end   <= i_nb_end;
            r_flags <= i_nb_flags;
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_flags = r_flags;

endmodule

>>> rtl/address_region_table.sv
// ----------------------------------------------------------------------------
// address_region_table
// Table of address regions kept in insertion order: register, unregister, find, range query.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_ENTRIES cells that rotates one place per clock
// while a command is scanned, so every entry passes the head cell once per
// command, in table order. A command is taken when start is high and busy is
// low; busy then stays high through the full rotation and a closing state, and
// no new command is taken until it falls. Each result is shown for one cycle
// with o_strobe and cannot be held off; the result marked last appears in the
// cycle in which busy falls. Range query results stream out during the
// rotation. Each one is held back until the next overlapping entry reaches the
// head cell, and is shown in the cycle after that. The final one is shown with
// last after the rotation.
// ----------------------------------------------------------------------------
module address_region_table #(
    parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDR_BITS     = art_pkg::DEF_ADDR_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  art_pkg::t_cmd_item  i_item,
    output logic                o_strobe,
    output art_pkg::t_result    o_result
);
    import art_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // ring wiring: cell i loads from cell i+1, the top cell from the feed
    logic [ADDR_BITS-1:0] c_start [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] c_end   [TABLE_ENTRIES];
    logic [FLAG_W-1:0]    c_flags [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] nb_start [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] nb_end   [TABLE_ENTRIES];
    logic [FLAG_W-1:0]    nb_flags [TABLE_ENTRIES];

    logic [ADDR_BITS-1:0] feed_start;
    logic [ADDR_BITS-1:0] feed_end;
    logic [FLAG_W-1:0]    feed_flags;
    t_cell_ctrl           cell_ctrl;

    t_state               r_state,   n_state;
    t_op                  r_op,      n_op;
    logic [ADDR_BITS-1:0] r_s,       n_s;
    logic [ADDR_BITS-1:0] r_e,       n_e;
    logic [FLAG_W-1:0]    r_fl,      n_fl;
    logic [ADDR_BITS-1:0] r_a,       n_a;
    t_status              r_reg_st,  n_reg_st;
    logic [IDX_W-1:0]     r_pos,     n_pos;
    logic [CNT_W-1:0]     r_count,   n_count;
    logic                 r_hit,     n_hit;
    logic                 r_app,     n_app;
    logic [IDX_W-1:0]     r_del_idx, n_del_idx;
    logic [ADDR_BITS-1:0] r_cap_s,   n_cap_s;
    logic [ADDR_BITS-1:0] r_cap_e,   n_cap_e;
    logic [FLAG_W-1:0]    r_cap_fl,  n_cap_fl;
    logic [COUNT_W-1:0]   r_k,       n_k;
    t_result              r_out,     n_out;
    logic                 r_stb,     n_stb;

    logic [ADDR_BITS-1:0] in_s;
    logic [ADDR_BITS-1:0] in_e;
    logic                 in_range;
    logic                 exact;
    logic                 contains;
    logic                 overlap;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            if (gi == TABLE_ENTRIES - 1) begin : g_top
                assign nb_start[gi] = feed_start;
                assign nb_end[gi]   = feed_end;
                assign nb_flags[gi] = feed_flags;
            end else begin : g_mid
                assign nb_start[gi] = c_start[gi+1];
                assign nb_end[gi]   = c_end[gi+1];
                assign nb_flags[gi] = c_flags[gi+1];
            end

            art_cell #(
                .ADDR_BITS (ADDR_BITS),
                .IDX_W     (IDX_W),
                .CELL_IDX  (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (cell_ctrl),
                .i_del_idx  (r_del_idx),
                .i_nb_start (nb_start[gi]),
                .i_nb_end   (nb_end[gi]),
                .i_nb_flags (nb_flags[gi]),
                .o_start    (c_start[gi]),
                .o_end      (c_end[gi]),
                .o_flags    (c_flags[gi])
            );
        end
    endgenerate

    assign in_s = ADDR_BITS'(i_item.region_start);
    assign in_e = ADDR_BITS'(i_item.region_end);

    // head cell compares
    assign in_range = CNT_W'(r_pos) < r_count;
    assign exact    = (c_start[0] == r_s) && (c_end[0] == r_e);
    assign contains = (r_a >= c_start[0]) && (r_a < c_end[0]);
    assign overlap  = (c_start[0] < r_e) && (c_end[0] > r_s);

    assign busy = (r_state != FSM_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_s       = r_s;
        n_e       = r_e;
        n_fl      = r_fl;
        n_a       = r_a;
        n_reg_st  = r_reg_st;
        n_pos     = r_pos;
        n_count   = r_count;
        n_hit     = r_hit;
        n_app     = r_app;
        n_del_idx = r_del_idx;
        n_cap_s   = r_cap_s;
        n_cap_e   = r_cap_e;
        n_cap_fl  = r_cap_fl;
        n_k       = r_k;
        n_out     = r_out;
        n_stb     = 1'b0;
        cell_ctrl  = '0;
        feed_start = c_start[0];
        feed_end   = c_end[0];
        feed_flags = c_flags[0];

        case (r_state)
            FSM_IDLE: begin
                if (start) begin
                    n_state   = FSM_SCAN;
                    n_op      = i_item.cmd;
                    n_s       = in_s;
                    n_e       = in_e;
                    n_fl      = i_item.region_flags;
                    n_a       = ADDR_BITS'(i_item.lookup_addr);
                    n_pos     = '0;
                    n_hit     = 1'b0;
                    n_app     = 1'b0;
                    n_del_idx = '0;
                    n_k       = '0;
                    if (in_e <= in_s) begin
                        n_reg_st = ST_INVALID;
                    end else if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                        n_reg_st = ST_FULL;
                    end else begin
                        n_reg_st = ST_OK;
                    end
                end
            end

            FSM_SCAN: begin
                cell_ctrl.rotate = 1'b1;
                n_pos = IDX_W'(r_pos + 1'b1);
                if (r_pos == IDX_W'(TABLE_ENTRIES - 1)) begin
                    n_state = FSM_FINISH;
                end
                case (r_op)
                    OP_REGISTER: begin
                        if (r_reg_st == ST_OK && !r_hit && !r_app) begin
                            if (in_range && exact) begin
                                feed_flags = r_fl;
                                n_hit      = 1'b1;
                            end else if (CNT_W'(r_pos) == r_count) begin
                                // first free slot reaches the head
                                feed_start = r_s;
                                feed_end   = r_e;
                                feed_flags = r_fl;
                                n_app      = 1'b1;
                            end
                        end
                    end
                    OP_UNREGISTER: begin
                        if (in_range && exact && !r_hit) begin
                            n_hit     = 1'b1;
                            n_del_idx = r_pos;
                        end
                    end
                    OP_FIND: begin
                        if (in_range && contains && !r_hit) begin
                            n_hit    = 1'b1;
                            n_cap_s  = c_start[0];
                            n_cap_e  = c_end[0];
                            n_cap_fl = c_flags[0];
                        end
                    end
                    OP_QUERY: begin
                        if (in_range && overlap && r_k < COUNT_W'(RESULT_LIMIT)) begin
                            // one result held back so the final one can carry last
                            if (r_k != '0) begin
                                n_stb             = 1'b1;
                                n_out             = '0;
                                n_out.status      = ST_OK;
                                n_out.entry_valid = 1'b1;
                                n_out.match_start = ADDR_W'(r_cap_s);
                                n_out.match_end   = ADDR_W'(r_cap_e);
                                n_out.match_flags = r_cap_fl;
                                n_out.match_count = r_k;
                            end
                            n_cap_s  = c_start[0];
                            n_cap_e  = c_end[0];
                            n_cap_fl = c_flags[0];
                            n_k      = COUNT_W'(r_k + 1'b1);
                        end
                    end
                    default: ;
                endcase
            end

            FSM_FINISH: begin
                n_state    = FSM_IDLE;
                n_stb      = 1'b1;
                n_out      = '0;
                n_out.last = 1'b1;
                case (r_op)
                    OP_REGISTER: begin
                        n_out.status = r_reg_st;
                        if (r_app) begin
                            n_count = CNT_W'(r_count + 1'b1);
                        end
                    end
                    OP_UNREGISTER: begin
                        if (r_hit) begin
                            n_out.status      = ST_OK;
                            cell_ctrl.compact = 1'b1;
                            feed_start        = '0;
                            feed_end          = '0;
                            feed_flags        = '0;
                            n_count           = CNT_W'(r_count - 1'b1);
                        end else begin
                            n_out.status = ST_NOTFOUND;
                        end
                    end
                    OP_FIND: begin
                        if (r_hit) begin
                            n_out.status      = ST_OK;
                            n_out.entry_valid = 1'b1;
                            n_out.match_start = ADDR_W'(r_cap_s);
                            n_out.match_end   = ADDR_W'(r_cap_e);
                            n_out.match_flags = r_cap_fl;
                        end else begin
                            n_out.status = ST_NOTFOUND;
                        end
                    end
                    OP_QUERY: begin
                        n_out.status = ST_OK;
                        if (r_k != '0) begin
                            n_out.entry_valid = 1'b1;
                            n_out.match_start = ADDR_W'(r_cap_s);
                            n_out.match_end   = ADDR_W'(r_cap_e);
                            n_out.match_flags = r_cap_fl;
                            n_out.match_count = r_k;
                        end
                    end
                    default: ;
                endcase
            end

            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_count <= '0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_s       <= n_s;
        r_e       <= n_e;
        r_fl      <= n_fl;
        r_a       <= n_a;
        r_reg_st  <= n_reg_st;
        r_pos     <= n_pos;
        r_hit     <= n_hit;
        r_app     <= n_app;
        r_del_idx <= n_del_idx;
        r_cap_s   <= n_cap_s;
        r_cap_e   <= n_cap_e;
        r_cap_fl  <= n_cap_fl;
        r_k       <= n_k;
        r_out     <= n_out;
    end

    assign o_strobe = r_stb;
    assign o_result = r_out;

endmodule
